// ----- hw/rtl/crtc_pkg.sv -----
// Shared types and constants for the cartridge real-time clock registers.
`default_nettype none
package crtc_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [2:0] SEL_SEC      = 3'd0;
	localparam logic [2:0] SEL_MIN      = 3'd1;
	localparam logic [2:0] SEL_HOUR     = 3'd2;
	localparam logic [2:0] SEL_DAY_LOW  = 3'd3;
	localparam logic [2:0] SEL_DAY_HIGH = 3'd4;

	localparam logic [5:0]  SEC_LAST  = 6'd59;
	localparam logic [5:0]  MIN_LAST  = 6'd59;
	localparam logic [4:0]  HOUR_LAST = 5'd23;
	localparam logic [8:0]  DAY_MAX   = 9'd511;
	localparam int          HALT_BIT  = 6;
	localparam int          CARRY_BIT = 7;
	localparam logic [15:0] TPS_RESET = 16'd32768;
	localparam logic [7:0]  READ_UNKNOWN = 8'hFF;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] reg_sel;
		logic [7:0] write_data;
	} crtc_item_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cartridge_rtc_registers.sv -----
// Real-time clock registers: read results pass through the input and output registers.
// One transaction per cycle unless a read is stalled; ticks and writes give no result.
// The input register executes against the clock state; reads land in an output register.
// Reset clears the time fields, halt and carry, and loads 32768 ticks per second.
// Configuration is taken at any cycle through a ready-high write port.
`default_nettype none
module cartridge_rtc_registers (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [2:0]  reg_sel,
	input  wire logic [7:0]  write_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import crtc_pkg::*;

	logic [15:0] tps_q;
	logic        valid_s1;
	crtc_item_t  item_s1;
	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        need_result;
	logic        adv;
	logic [7:0]  rdata;

	assign cfg_ready   = 1'b1;
	assign need_result = valid_s1 && (item_s1.op == OP_READ);
	assign adv         = valid_s1 && (!need_result || !out_valid_q || out_ready);
	assign in_ready    = !valid_s1 || adv;
	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= TPS_RESET;
		end else if (cfg_valid) begin
			tps_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{op: op, reg_sel: reg_sel, write_data: write_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && need_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && need_result) begin
			read_data_q <= rdata;
		end
	end

	crtc_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.exec             (adv),
		.item             (item_s1),
		.ticks_per_second (tps_q),
		.rdata            (rdata)
	);

	// A result appears only after a read transaction leaves the input register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && need_result))
		else $error("result without a read transaction");

	// A stalled input register keeps its transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled transaction lost");

	// A pending result is never overwritten by a new read.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(read_data_q))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- hw/rtl/crtc_core.sv -----
// Clock state, counter cascade, register writes and the register read mux.
`default_nettype none
module crtc_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              exec,
	input  wire crtc_pkg::crtc_item_t item,
	input  wire logic [15:0]       ticks_per_second,
	output logic [7:0]             rdata
);
	import crtc_pkg::*;

	logic [15:0] prescaler_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [8:0]  day_q;
	logic        halt_q;
	logic        carry_q;

	logic [15:0] prescaler_d;
	logic [5:0]  sec_d;
	logic [5:0]  min_d;
	logic [4:0]  hour_d;
	logic [8:0]  day_d;
	logic        halt_d;
	logic        carry_d;

	logic [15:0] limit;
	logic [16:0] pre_inc;
	logic        sec_tick;
	logic        min_tick;
	logic        hour_tick;
	logic        day_tick;
	logic        new_halt;

	always_comb begin
		limit    = (ticks_per_second == 16'd0) ? 16'd1 : ticks_per_second;
		pre_inc  = {1'b0, prescaler_q} + 17'd1;
		sec_tick = (pre_inc >= {1'b0, limit});
		min_tick  = sec_tick && (sec_q == SEC_LAST);
		hour_tick = min_tick && (min_q == MIN_LAST);
		day_tick  = hour_tick && (hour_q == HOUR_LAST);
		new_halt  = item.write_data[HALT_BIT];
	end

	always_comb begin
		prescaler_d = prescaler_q;
		sec_d       = sec_q;
		min_d       = min_q;
		hour_d      = hour_q;
		day_d       = day_q;
		halt_d      = halt_q;
		carry_d     = carry_q;
		if (exec) begin
			case (item.op)
				OP_TICK: begin
					if (!halt_q) begin
						prescaler_d = sec_tick ? 16'd0 : pre_inc[15:0];
						if (sec_tick) begin
							sec_d = (sec_q == SEC_LAST) ? 6'd0 : sec_q + 6'd1;
						end
						if (min_tick) begin
							min_d = (min_q == MIN_LAST) ? 6'd0 : min_q + 6'd1;
						end
						if (hour_tick) begin
							hour_d = (hour_q == HOUR_LAST) ? 5'd0 : hour_q + 5'd1;
						end
						if (day_tick) begin
							if (day_q == DAY_MAX) begin
								day_d   = 9'd0;
								carry_d = 1'b1;
							end else begin
								day_d = day_q + 9'd1;
							end
						end
					end
				end
				OP_WRITE: begin
					if (item.reg_sel == SEL_DAY_HIGH) begin
						if (halt_q || new_halt) begin
							day_d = {item.write_data[0], day_q[7:0]};
						end
						halt_d  = new_halt;
						carry_d = item.write_data[CARRY_BIT];
					end else if (halt_q) begin
						case (item.reg_sel)
							SEL_SEC: begin
								sec_d       = item.write_data[5:0];
								prescaler_d = 16'd0;
							end
							SEL_MIN:     min_d  = item.write_data[5:0];
							SEL_HOUR:    hour_d = item.write_data[4:0];
							SEL_DAY_LOW: day_d  = {day_q[8], item.write_data};
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescaler_q <= '0;
			sec_q       <= '0;
			min_q       <= '0;
			hour_q      <= '0;
			day_q       <= '0;
			halt_q      <= 1'b0;
			carry_q     <= 1'b0;
		end else begin
			prescaler_q <= prescaler_d;
			sec_q       <= sec_d;
			min_q       <= min_d;
			hour_q      <= hour_d;
			day_q       <= day_d;
			halt_q      <= halt_d;
			carry_q     <= carry_d;
		end
	end

	always_comb begin
		case (item.reg_sel)
			SEL_SEC:      rdata = {2'b00, sec_q};
			SEL_MIN:      rdata = {2'b00, min_q};
			SEL_HOUR:     rdata = {3'b000, hour_q};
			SEL_DAY_LOW:  rdata = day_q[7:0];
			SEL_DAY_HIGH: rdata = {carry_q, halt_q, 5'b00000, day_q[8]};
			default:      rdata = READ_UNKNOWN;
		endcase
	end

	// A halted clock ignores ticks entirely.
	assert property (@(posedge clk) disable iff (!arst_n)
		exec && item.op == OP_TICK && halt_q |=> $stable(prescaler_q) && $stable(sec_q))
		else $error("halted clock advanced on a tick");

	// The carry flag only rises on a day rollover or a day high write.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(carry_q) |-> $past(exec && (item.op == OP_TICK ||
			(item.op == OP_WRITE && item.reg_sel == SEL_DAY_HIGH))))
		else $error("carry flag set without a rollover or write");

	// Time fields change only when a transaction executes.
	assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(sec_q) && $stable(day_q) && $stable(halt_q))
		else $error("clock state changed without a transaction");

endmodule
`default_nettype wire
